/* hdl/tsq_pkg.sv */
package tsq_pkg;

  localparam int DEPTH       = 64;
  localparam int HANDLE_BITS = 16;
  localparam int SEC_BITS    = 32;
  localparam int USEC_BITS   = 20;
  localparam int KEY_BITS    = SEC_BITS + USEC_BITS;
  localparam int CNT_BITS    = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  // what every cell does in the update cycle
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_SHIFT_GE,
    ACT_SHIFT_ALL
  } act_t;

  typedef struct packed {
    logic                   valid;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                   eval;
    act_t                   act;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } bcast_t;

  typedef struct packed {
    logic gt;
    logic ge;
    logic eq;
  } flags_t;

endpackage

/* hdl/tsq_cell.sv */
module tsq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  tsq_pkg::bcast_t bc,
  input  tsq_pkg::entry_t left,
  input  tsq_pkg::flags_t left_flags,
  input  tsq_pkg::entry_t right,
  output tsq_pkg::entry_t ent,
  output tsq_pkg::flags_t flags
);
  import tsq_pkg::*;

  entry_t entry_r, entry_nxt;
  flags_t flags_r, flags_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (bc.act)
      ACT_INSERT: begin
        // keys are sorted, so gt is a run from the boundary to the end
        if (flags_r.gt) begin
          if (left_flags.gt) begin
            entry_nxt = left;
          end else begin
            entry_nxt.valid  = 1'b1;
            entry_nxt.key    = bc.key;
            entry_nxt.handle = bc.handle;
          end
        end
      end
      ACT_SHIFT_GE: begin
        if (flags_r.ge) begin
          entry_nxt = right;
        end
      end
      ACT_SHIFT_ALL: entry_nxt = right;
      default: ;
    endcase
  end

  always_comb begin
    flags_nxt = flags_r;
    if (bc.eval) begin
      flags_nxt.gt = !entry_r.valid || (entry_r.key > bc.key);
      flags_nxt.ge = entry_r.valid && (entry_r.key >= bc.key);
      flags_nxt.eq = entry_r.valid && (entry_r.key == bc.key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
      flags_r       <= '0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
      flags_r       <= flags_nxt;
    end
    entry_r.key    <= entry_nxt.key;
    entry_r.handle <= entry_nxt.handle;
  end

  assign ent   = entry_r;
  assign flags = flags_r;

endmodule

/* hdl/timestamp_sorted_queue.sv */
// channel  | ports                                           | handshake
// ---------+-------------------------------------------------+------------------------
// command  | in_cmd, in_key_sec, in_key_usec, in_handle_in   | start high, busy low
// result   | out_status, out_handle_out, out_entry_count,    | out_strobe, one cycle
//          | out_became_head                                 |
//
// a command is handled in order: compare in every cell, shift the row, show the result.
// the result beat is on the ports in the cycle after the row update; a new command
// may be taken in that same cycle.
// synchronous reset empties the row (valid bits only) and the count.
// the result side cannot stall; busy is the only back pressure on commands.
module timestamp_sorted_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_cmd,
  input  logic [tsq_pkg::SEC_BITS-1:0]    in_key_sec,
  input  logic [tsq_pkg::USEC_BITS-1:0]   in_key_usec,
  input  logic [tsq_pkg::HANDLE_BITS-1:0] in_handle_in,
  output logic                            out_strobe,
  output logic [1:0]                      out_status,
  output logic [tsq_pkg::HANDLE_BITS-1:0] out_handle_out,
  output logic [tsq_pkg::CNT_BITS-1:0]    out_entry_count,
  output logic                            out_became_head
);
  import tsq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_APPLY} state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic                   strobe_r, strobe_nxt;
  status_t                status_r, status_nxt;
  logic [HANDLE_BITS-1:0] hout_r, hout_nxt;
  logic                   head_r, head_nxt;

  bcast_t                 bc;
  act_t                   act;
  entry_t                 ent   [DEPTH];
  flags_t                 flg   [DEPTH];
  entry_t                 lft   [DEPTH];
  flags_t                 lflg  [DEPTH];
  entry_t                 rgt   [DEPTH];
  logic [DEPTH-1:0]       valid_vec, eq_vec, first_vec;
  logic [HANDLE_BITS-1:0] del_handle;
  logic                   full, empty, found, accept;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign lft[g]  = '0;
        assign lflg[g] = '0;
      end else begin : g_mid
        assign lft[g]  = ent[g-1];
        assign lflg[g] = flg[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign rgt[g] = '0;
      end else begin : g_inner
        assign rgt[g] = ent[g+1];
      end

      tsq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .bc         (bc),
        .left       (lft[g]),
        .left_flags (lflg[g]),
        .right      (rgt[g]),
        .ent        (ent[g]),
        .flags      (flg[g])
      );

      assign valid_vec[g] = ent[g].valid;
      assign eq_vec[g]    = flg[g].eq;
      assign first_vec[g] = flg[g].ge && !lflg[g].ge;
    end
  endgenerate

  assign accept = start && (state_r == S_IDLE);
  assign full   = (count_r == CNT_BITS'(DEPTH));
  assign empty  = (count_r == '0);
  assign found  = |eq_vec;

  // first entry at or past the key is the one removed on delete
  always_comb begin
    del_handle = '0;
    for (int i = 0; i < DEPTH; i++) begin
      del_handle = del_handle | ({HANDLE_BITS{first_vec[i]}} & ent[i].handle);
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_INSERT: act = full  ? ACT_HOLD : ACT_INSERT;
      CMD_DELETE: act = found ? ACT_SHIFT_GE : ACT_HOLD;
      CMD_POP:    act = empty ? ACT_HOLD : ACT_SHIFT_ALL;
      default:    act = ACT_HOLD;
    endcase
  end

  always_comb begin
    bc.eval   = (state_r == S_EVAL);
    bc.act    = (state_r == S_APPLY) ? act : ACT_HOLD;
    bc.key    = key_r;
    bc.handle = handle_r;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    handle_nxt = handle_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    hout_nxt   = hout_r;
    head_nxt   = head_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = cmd_t'(in_cmd);
          key_nxt    = {in_key_sec, in_key_usec};
          handle_nxt = in_handle_in;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: state_nxt = S_APPLY;
      S_APPLY: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        status_nxt = STAT_OK;
        hout_nxt   = '0;
        head_nxt   = 1'b0;
        case (cmd_r)
          CMD_INSERT: begin
            if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
              head_nxt  = flg[0].gt;
            end
          end
          CMD_DELETE: begin
            if (found) begin
              count_nxt = count_r - 1'b1;
              hout_nxt  = del_handle;
            end else begin
              status_nxt = STAT_MISS;
            end
          end
          default: begin
            if (empty) begin
              status_nxt = STAT_MISS;
            end else begin
              hout_nxt = ent[0].handle;
              if (cmd_r == CMD_POP) begin
                count_nxt = count_r - 1'b1;
              end
            end
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    head_r   <= head_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_handle_out  = hout_r;
  assign out_entry_count = count_r;
  assign out_became_head = head_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("entry count above depth");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("valid entries not packed at the head");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(valid_vec) == int'(count_r)))
    else $error("entry count disagrees with valid cells");

  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |=> strobe_r)
    else $error("result beat missing after row update");

  a_head_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && head_r) |-> (status_r == STAT_OK && $past(cmd_r) == CMD_INSERT))
    else $error("head flag on a non-insert result");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tsq_pkg::*;

  typedef struct {
    status_t                status;
    logic [HANDLE_BITS-1:0] handle;
    logic [CNT_BITS-1:0]    count;
    logic                   head;
  } queue_reply_t;

  // mirror of the sorted row plus the replies still owed by the block
  class queue_tracker;
    logic [KEY_BITS-1:0]    keys[$];
    logic [HANDLE_BITS-1:0] handles[$];
    queue_reply_t           owed[$];
    int                     failures;

    function new();
      failures = 0;
    endfunction

    function void note_command(cmd_t cmd, logic [SEC_BITS-1:0] sec,
                               logic [USEC_BITS-1:0] usec, logic [HANDLE_BITS-1:0] h);
      logic [KEY_BITS-1:0] key;
      queue_reply_t        r;
      int                  pos;
      key      = {sec, usec};
      r.status = STAT_OK;
      r.handle = '0;
      r.head   = 1'b0;
      pos      = 0;
      case (cmd)
        CMD_INSERT: begin
          if (keys.size() >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            // equal keys go behind the ones already queued
            while (pos < keys.size() && keys[pos] <= key) pos++;
            keys.insert(pos, key);
            handles.insert(pos, h);
            r.head = (pos == 0);
          end
        end
        CMD_DELETE: begin
          while (pos < keys.size() && keys[pos] != key) pos++;
          if (pos >= keys.size()) begin
            r.status = STAT_MISS;
          end else begin
            r.handle = handles[pos];
            keys.delete(pos);
            handles.delete(pos);
          end
        end
        CMD_POP: begin
          if (keys.size() == 0) begin
            r.status = STAT_MISS;
          end else begin
            r.handle = handles[0];
            keys.delete(0);
            handles.delete(0);
          end
        end
        default: begin
          if (keys.size() == 0) r.status = STAT_MISS;
          else r.handle = handles[0];
        end
      endcase
      r.count = CNT_BITS'(keys.size());
      owed.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [HANDLE_BITS-1:0] h,
                               logic [CNT_BITS-1:0] cnt, logic hd);
      queue_reply_t want;
      if (owed.size() == 0) begin
        $error("result beat with nothing outstanding");
        failures++;
        return;
      end
      want = owed.pop_front();
      if (st !== want.status) begin
        $error("status expected %0d got %0d", want.status, st);
        failures++;
      end
      if (h !== want.handle) begin
        $error("handle_out expected %h got %h", want.handle, h);
        failures++;
      end
      if (cnt !== want.count) begin
        $error("entry_count expected %0d got %0d", want.count, cnt);
        failures++;
      end
      if (hd !== want.head) begin
        $error("became_head expected %0d got %0d", want.head, hd);
        failures++;
      end
    endfunction

    function logic [KEY_BITS-1:0] stored_key();
      if (keys.size() == 0) return '0;
      return keys[$urandom_range(0, keys.size() - 1)];
    endfunction
  endclass

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   start           = 1'b0;
  logic [1:0]             in_cmd          = '0;
  logic [SEC_BITS-1:0]    in_key_sec      = '0;
  logic [USEC_BITS-1:0]   in_key_usec     = '0;
  logic [HANDLE_BITS-1:0] in_handle_in    = '0;
  logic                   busy;
  logic                   out_strobe;
  logic [1:0]             out_status;
  logic [HANDLE_BITS-1:0] out_handle_out;
  logic [CNT_BITS-1:0]    out_entry_count;
  logic                   out_became_head;

  queue_tracker tracker = new();
  bit           idle_on = 1'b1;

  always #5 clk = ~clk;

  timestamp_sorted_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key_sec      (in_key_sec),
    .in_key_usec     (in_key_usec),
    .in_handle_in    (in_handle_in),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_handle_out  (out_handle_out),
    .out_entry_count (out_entry_count),
    .out_became_head (out_became_head)
  );

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      tracker.check_result(out_status, out_handle_out, out_entry_count, out_became_head);
  end

  // one command beat, with an optional idle gap in front of it
  task automatic issue(cmd_t cmd, logic [SEC_BITS-1:0] sec, logic [USEC_BITS-1:0] usec,
                       logic [HANDLE_BITS-1:0] h);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_key_sec   <= sec;
    in_key_usec  <= usec;
    in_handle_in <= h;
    do @(posedge clk); while (busy);
    tracker.note_command(cmd, sec, usec, h);
  endtask

  task automatic random_key(output logic [SEC_BITS-1:0] sec, output logic [USEC_BITS-1:0] usec);
    logic [KEY_BITS-1:0] k;
    int                  pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      // narrow pool so equal keys are common
      sec  = $urandom_range(0, 3);
      usec = USEC_BITS'($urandom_range(0, 3));
    end else if (pick < 8) begin
      sec  = $urandom;
      usec = USEC_BITS'($urandom);
    end else if (pick == 8) begin
      sec  = $urandom_range(0, 1) ? '1 : '0;
      usec = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      k    = tracker.stored_key();
      sec  = k[KEY_BITS-1:USEC_BITS];
      usec = k[USEC_BITS-1:0];
    end
  endtask

  initial begin
    logic [SEC_BITS-1:0]  sec;
    logic [USEC_BITS-1:0] usec;
    logic [KEY_BITS-1:0]  k;
    cmd_t                 cmd;
    int                   mode;
    int                   roll;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // empty queue, extremes, equal keys, raw usec beyond one second
    issue(CMD_PEEK,   '0, '0, '0);
    issue(CMD_POP,    '0, '0, '0);
    issue(CMD_DELETE, '0, '0, '0);
    issue(CMD_INSERT, 32'd5, 20'd10, 16'h1111);
    issue(CMD_INSERT, '1, '1, '1);
    issue(CMD_INSERT, '0, '0, '0);
    issue(CMD_INSERT, 32'd5, 20'd10, 16'h2222);
    issue(CMD_INSERT, 32'd5, 20'd10, 16'h3333);
    issue(CMD_PEEK,   '0, '0, '0);
    issue(CMD_DELETE, 32'd5, 20'd10, '0);
    issue(CMD_DELETE, 32'd5, 20'd11, '0);
    issue(CMD_INSERT, 32'd5, 20'd999999, 16'hAAAA);
    issue(CMD_INSERT, 32'd5, 20'd1000000, 16'h5555);
    issue(CMD_INSERT, 32'h8000_0000, 20'h80000, 16'h8001);
    issue(CMD_POP,    '0, '0, '0);
    issue(CMD_DELETE, '1, '1, '0);
    issue(CMD_PEEK,   '0, '0, '0);
    issue(CMD_POP,    '0, '0, '0);
    issue(CMD_POP,    '0, '0, '0);
    issue(CMD_POP,    '0, '0, '0);
    issue(CMD_POP,    '0, '0, '0);
    issue(CMD_POP,    '0, '0, '0);
    issue(CMD_PEEK,   '0, '0, '0);

    // random phase: segments that fill, drain or mix; first one always fills
    mode = 0;
    for (int n = 0; n < 1100; n++) begin
      if (n > 0 && n % 60 == 0) mode = $urandom_range(0, 2);
      idle_on = !(n >= 400 && n < 600);
      roll = $urandom_range(0, 99);
      case (mode)
        0:       cmd = (roll < 85) ? CMD_INSERT : cmd_t'($urandom_range(1, 3));
        1:       cmd = (roll < 20) ? CMD_INSERT : cmd_t'($urandom_range(1, 3));
        default: cmd = cmd_t'($urandom_range(0, 3));
      endcase
      if (cmd == CMD_DELETE && tracker.keys.size() != 0 && $urandom_range(0, 99) < 70) begin
        k    = tracker.stored_key();
        sec  = k[KEY_BITS-1:USEC_BITS];
        usec = k[USEC_BITS-1:0];
      end else begin
        random_key(sec, usec);
      end
      issue(cmd, sec, usec, HANDLE_BITS'($urandom));
    end

    start <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.failures == 0 && tracker.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
